FILE: hw/rtl/source_text_tokenizer_core_assert.svh
// Assertion macros for the source text tokenizer checker.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STTK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STTK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sttk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Token kinds, keyword patterns, sizing constants and the queue entry type
// that the scanner front end hands to the token emitter.
// ----------------------------------------------------------------------------
package sttk_pkg;

    // Default length caps for identifiers and numbers.
    localparam int MAX_IDENT_CHARS_DEF   = 19;
    localparam int MAX_NUMBER_DIGITS_DEF = 9;

    // The text fields on the ports always carry this many bytes.
    localparam int TEXT_BYTES = 19;
    localparam int TEXT_W     = TEXT_BYTES * 8;
    localparam int NUMBER_W   = 30;
    localparam int LENGTH_W   = 5;

    // Entries in the queue between the front end and the emitter.
    localparam int QUEUE_DEPTH = 4;

    // Token kinds as seen on the kind port.
    typedef enum logic [2:0] {
        KIND_END    = 3'd0,
        KIND_FN     = 3'd1,
        KIND_INT    = 3'd2,
        KIND_YELL   = 3'd3,
        KIND_IDENT  = 3'd4,
        KIND_NUMBER = 3'd5,
        KIND_CHAR   = 3'd6
    } kind_t;

    // Keywords packed with the first character in the lowest byte.
    localparam logic [31:0] KW_FN_TEXT   = 32'h0000_6E66;
    localparam logic [31:0] KW_INT_TEXT  = 32'h0074_6E69;
    localparam logic [31:0] KW_YELL_TEXT = 32'h6C6C_6579;
    localparam logic [LENGTH_W-1:0] KW_FN_LEN   = 5'd2;
    localparam logic [LENGTH_W-1:0] KW_INT_LEN  = 5'd3;
    localparam logic [LENGTH_W-1:0] KW_YELL_LEN = 5'd4;

    // Special bytes.
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;

    // Results of one input byte: an optional flushed identifier or number,
    // then an optional character or end token.
    typedef struct packed {
        logic                has_first;
        kind_t               first_kind;
        logic [NUMBER_W-1:0] first_number;
        logic [LENGTH_W-1:0] first_length;
        logic [TEXT_W-1:0]   first_text;
        logic                has_second;
        kind_t               second_kind;
        logic [7:0]          second_char;
    } entry_t;

endpackage

FILE: hw/rtl/sttk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer scanner front end
// Accepts one byte per cycle while the queue has room, classifies it, tracks the
// pending identifier or number and pushes the tokens that each byte completes into the queue.
// ----------------------------------------------------------------------------
module sttk_front #(
    parameter int MAX_IDENT_CHARS   = sttk_pkg::MAX_IDENT_CHARS_DEF,
    parameter int MAX_NUMBER_DIGITS = sttk_pkg::MAX_NUMBER_DIGITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  logic [7:0]        char_code,
    input  logic              end_of_input,
    input  logic              queue_full,
    output logic              push,
    output sttk_pkg::entry_t  push_entry
);

    localparam int CNT_W = $clog2(MAX_IDENT_CHARS + 1);
    localparam int IDX_W = (MAX_IDENT_CHARS > 1) ? $clog2(MAX_IDENT_CHARS) : 1;
    localparam int DIG_W = $clog2(MAX_NUMBER_DIGITS + 1);
    localparam int NW    = sttk_pkg::NUMBER_W;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_IDENT   = 4'b0010,
        MODE_NUMBER  = 4'b0100,
        MODE_COMMENT = 4'b1000
    } scan_mode_t;

    scan_mode_t       mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [NW-1:0]    accum_reg, accum_next;
    logic [DIG_W-1:0] digits_reg, digits_next;
    logic [7:0]       buf_reg [MAX_IDENT_CHARS];

    logic                              accept;
    logic                              is_space, is_alpha, is_digit, is_hash, is_eol;
    logic [3:0]                        digit_val;
    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_idx;
    logic                              do_flush, do_start;
    logic                              second_ok;
    sttk_pkg::kind_t                   second_kind;
    logic [7:0]                        second_char;
    logic [sttk_pkg::TEXT_W-1:0]       held_text;
    logic [sttk_pkg::LENGTH_W-1:0]     held_len;
    sttk_pkg::kind_t                   ident_kind;

    // The queue must have room before a byte transfer is taken.
    assign src_stall = queue_full;
    assign accept    = src_valid && !src_stall;

    // Byte classes.
    assign is_space  = (char_code == 8'd32) || (char_code inside {[8'd9:8'd13]});
    assign is_alpha  = char_code inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    assign is_digit  = char_code inside {[8'h30:8'h39]};
    assign is_hash   = (char_code == sttk_pkg::CHAR_HASH);
    assign is_eol    = (char_code == sttk_pkg::CHAR_LF) || (char_code == sttk_pkg::CHAR_CR);
    assign digit_val = char_code[3:0];

    // Held identifier text, with bytes past the count forced to zero.
    assign held_len = sttk_pkg::LENGTH_W'(count_reg);
    for (genvar i = 0; i < sttk_pkg::TEXT_BYTES; i++) begin : g_text
        if (i < MAX_IDENT_CHARS) begin : g_held
            assign held_text[i*8 +: 8] = (count_reg > CNT_W'(i)) ? buf_reg[i] : 8'h00;
        end else begin : g_unused
            assign held_text[i*8 +: 8] = 8'h00;
        end
    end

    // Keyword classification of the held identifier.
    always_comb
    begin
        ident_kind = sttk_pkg::KIND_IDENT;
        if ((held_len == sttk_pkg::KW_FN_LEN) && (held_text[31:0] == sttk_pkg::KW_FN_TEXT)) begin
            ident_kind = sttk_pkg::KIND_FN;
        end else if ((held_len == sttk_pkg::KW_INT_LEN)
                     && (held_text[31:0] == sttk_pkg::KW_INT_TEXT)) begin
            ident_kind = sttk_pkg::KIND_INT;
        end else if ((held_len == sttk_pkg::KW_YELL_LEN)
                     && (held_text[31:0] == sttk_pkg::KW_YELL_TEXT)) begin
            ident_kind = sttk_pkg::KIND_YELL;
        end
    end

    // Scanner next-state logic for one accepted byte.
    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        wr_en       = 1'b0;
        wr_idx      = count_reg[IDX_W-1:0];
        do_flush    = 1'b0;
        do_start    = 1'b0;
        second_ok   = 1'b0;
        second_kind = sttk_pkg::KIND_END;
        second_char = 8'h00;

        if (accept) begin
            if (end_of_input) begin
                do_flush  = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER);
                second_ok = 1'b1;
                mode_next = MODE_IDLE;
            end else begin
                case (mode_reg)
                    MODE_IDENT:
                    begin
                        if ((is_alpha || is_digit) && (count_reg < CNT_W'(MAX_IDENT_CHARS))) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            do_flush = 1'b1;
                            do_start = 1'b1;
                        end
                    end
                    MODE_NUMBER:
                    begin
                        if (is_digit && (digits_reg < DIG_W'(MAX_NUMBER_DIGITS))) begin
                            accum_next  = {accum_reg[NW-4:0], 3'b000}
                                        + {accum_reg[NW-2:0], 1'b0}
                                        + NW'(digit_val);
                            digits_next = digits_reg + DIG_W'(1);
                        end else begin
                            do_flush = 1'b1;
                            do_start = 1'b1;
                        end
                    end
                    MODE_COMMENT:
                    begin
                        if (is_eol) begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        do_start = 1'b1;
                    end
                endcase

                // The byte that does not continue a token starts the next one.
                if (do_start) begin
                    if (is_space) begin
                        mode_next = MODE_IDLE;
                    end else if (is_alpha) begin
                        wr_en      = 1'b1;
                        wr_idx     = '0;
                        count_next = CNT_W'(1);
                        mode_next  = MODE_IDENT;
                    end else if (is_digit) begin
                        accum_next  = NW'(digit_val);
                        digits_next = DIG_W'(1);
                        mode_next   = MODE_NUMBER;
                    end else if (is_hash) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        second_ok   = 1'b1;
                        second_kind = sttk_pkg::KIND_CHAR;
                        second_char = char_code;
                        mode_next   = MODE_IDLE;
                    end
                end
            end
        end
    end

    // Queue entry for the tokens completed by this byte.
    always_comb
    begin
        push                    = accept && (do_flush || second_ok);
        push_entry.has_first    = do_flush;
        push_entry.first_kind   = (mode_reg == MODE_IDENT) ? ident_kind : sttk_pkg::KIND_NUMBER;
        push_entry.first_number = (mode_reg == MODE_NUMBER) ? accum_reg : '0;
        push_entry.first_length = (mode_reg == MODE_IDENT) ? held_len : '0;
        push_entry.first_text   = (mode_reg == MODE_IDENT) ? held_text : '0;
        push_entry.has_second   = second_ok;
        push_entry.second_kind  = second_kind;
        push_entry.second_char  = second_char;
    end

    // Scanner control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            count_reg  <= '0;
            accum_reg  <= '0;
            digits_reg <= '0;
        end else begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            accum_reg  <= accum_next;
            digits_reg <= digits_next;
        end
    end

    // Identifier character buffer; entries are read only below the count.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            buf_reg[wr_idx] <= char_code;
        end
    end

endmodule

FILE: hw/rtl/sttk_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer token queue
// A short first-in first-out queue of per-byte token entries between the
// scanner front end and the token emitter.
// ----------------------------------------------------------------------------
module sttk_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sttk_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output sttk_pkg::entry_t  head_entry
);

    localparam int DEPTH = sttk_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sttk_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update with wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        fill_next = fill_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/sttk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer token emitter
// Takes queue entries and presents their tokens one per transfer through an
// output register, the flushed token before the character or end token.
// ----------------------------------------------------------------------------
module sttk_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  sttk_pkg::entry_t  head_entry,
    output logic              pop,
    output logic              tok_valid,
    input  logic              tok_stall,
    output logic [2:0]        kind,
    output logic [7:0]        char_value,
    output logic [29:0]       number_value,
    output logic [4:0]        ident_length,
    output logic [63:0]       ident_text_low,
    output logic [63:0]       ident_text_mid,
    output logic [23:0]       ident_text_high,
    output logic              last_of_run
);

    logic                                valid_reg, valid_next;
    logic                                phase_reg, phase_next;
    sttk_pkg::kind_t                     kind_reg;
    logic [7:0]                          char_reg;
    logic [sttk_pkg::NUMBER_W-1:0]       number_reg;
    logic [sttk_pkg::LENGTH_W-1:0]       length_reg;
    logic [sttk_pkg::TEXT_W-1:0]         text_reg;
    logic                                last_reg;
    logic                                load;
    logic                                emit_first;

    // Load the output register from a valid queue head whenever it is empty or being drained.
    assign load       = head_valid && (!valid_reg || !tok_stall);
    assign emit_first = head_entry.has_first && !phase_reg;

    always_comb
    begin
        pop        = 1'b0;
        phase_next = phase_reg;
        valid_next = valid_reg && tok_stall;
        if (load) begin
            valid_next = 1'b1;
            if (emit_first && head_entry.has_second) begin
                phase_next = 1'b1;
            end else begin
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // Token payload register.
    always_ff @(posedge clk)
    begin
        if (load) begin
            if (emit_first) begin
                kind_reg   <= head_entry.first_kind;
                char_reg   <= 8'h00;
                number_reg <= head_entry.first_number;
                length_reg <= head_entry.first_length;
                text_reg   <= head_entry.first_text;
                last_reg   <= !head_entry.has_second;
            end else begin
                kind_reg   <= head_entry.second_kind;
                char_reg   <= head_entry.second_char;
                number_reg <= '0;
                length_reg <= '0;
                text_reg   <= '0;
                last_reg   <= 1'b1;
            end
        end
    end

    assign tok_valid       = valid_reg;
    assign kind            = kind_reg;
    assign char_value      = char_reg;
    assign number_value    = number_reg;
    assign ident_length    = length_reg;
    assign ident_text_low  = text_reg[63:0];
    assign ident_text_mid  = text_reg[127:64];
    assign ident_text_high = text_reg[151:128];
    assign last_of_run     = last_reg;

endmodule

FILE: hw/rtl/source_text_tokenizer_core.sv
`timescale 1ns / 1ps
// A token completed by a byte transfer is written into the queue slot and then loaded into
// the emitter output register, and transfers from there while tok_stall is low.
// Throughput: one byte and at most one token per cycle, set by the single output register
// of the emitter; a byte giving two tokens takes two output transfers, and src_stall is high
// while the four-entry queue is full.
// Reset: rst_n clears scanner state, queue pointers and output valid; no clearing pass runs.
// ----------------------------------------------------------------------------
// Source text tokenizer core
// Scanner front end, token queue and token emitter joined into one block.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core #(
    parameter int MAX_IDENT_CHARS   = sttk_pkg::MAX_IDENT_CHARS_DEF,
    parameter int MAX_NUMBER_DIGITS = sttk_pkg::MAX_NUMBER_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_input,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [2:0]  kind,
    output logic [7:0]  char_value,
    output logic [29:0] number_value,
    output logic [4:0]  ident_length,
    output logic [63:0] ident_text_low,
    output logic [63:0] ident_text_mid,
    output logic [23:0] ident_text_high,
    output logic        last_of_run
);

    logic              queue_full;
    logic              push;
    sttk_pkg::entry_t  push_entry;
    logic              pop;
    logic              head_valid;
    sttk_pkg::entry_t  head_entry;

    // Scanner front end.
    sttk_front #(
        .MAX_IDENT_CHARS   (MAX_IDENT_CHARS),
        .MAX_NUMBER_DIGITS (MAX_NUMBER_DIGITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .queue_full   (queue_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    // Queue between front end and emitter.
    sttk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Token emitter.
    sttk_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_entry      (head_entry),
        .pop             (pop),
        .tok_valid       (tok_valid),
        .tok_stall       (tok_stall),
        .kind            (kind),
        .char_value      (char_value),
        .number_value    (number_value),
        .ident_length    (ident_length),
        .ident_text_low  (ident_text_low),
        .ident_text_mid  (ident_text_mid),
        .ident_text_high (ident_text_high),
        .last_of_run     (last_of_run)
    );

endmodule

FILE: hw/rtl/sttk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer port checker
// Watches the ports of the tokenizer core for token output rules, and is
// bound to every instance of the core.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_core_assert.svh"

module sttk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        src_valid,
    input logic        src_stall,
    input logic [7:0]  char_code,
    input logic        end_of_input,
    input logic        tok_valid,
    input logic        tok_stall,
    input logic [2:0]  kind,
    input logic [7:0]  char_value,
    input logic [29:0] number_value,
    input logic [4:0]  ident_length,
    input logic [63:0] ident_text_low,
    input logic [63:0] ident_text_mid,
    input logic [23:0] ident_text_high,
    input logic        last_of_run
);

    // A stalled byte transfer holds its valid and payload.
    `STTK_ASSERT_NEXT(a_src_hold, src_valid && src_stall,
        src_valid && $stable(char_code) && $stable(end_of_input),
        "stalled byte changed")

    // A stalled token transfer holds its valid, kind, number, text and last flag.
    `STTK_ASSERT_NEXT(a_tok_hold, tok_valid && tok_stall,
        tok_valid && $stable(kind) && $stable(number_value) && $stable(ident_text_low)
        && $stable(ident_text_mid) && $stable(ident_text_high) && $stable(last_of_run),
        "stalled token changed")

    // An end token always closes the results of its byte and carries zero length and number.
    `STTK_ASSERT_SAME(a_end_last, tok_valid && (kind == sttk_pkg::KIND_END),
        last_of_run && (ident_length == 5'd0) && (number_value == 30'd0),
        "end token malformed")

    // A character token is always the final result of its byte.
    `STTK_ASSERT_SAME(a_char_last, tok_valid && (kind == sttk_pkg::KIND_CHAR),
        last_of_run && (ident_length == 5'd0) && (ident_text_low == 64'd0),
        "character token malformed")

    // The yell keyword carries exactly its four characters.
    `STTK_ASSERT_SAME(a_yell_text, tok_valid && (kind == sttk_pkg::KIND_YELL),
        (ident_length == sttk_pkg::KW_YELL_LEN)
        && (ident_text_low == 64'(sttk_pkg::KW_YELL_TEXT)) && (char_value == 8'd0),
        "yell keyword malformed")

endmodule

bind source_text_tokenizer_core sttk_checker u_sttk_checker (.*);

FILE: tb/tb_source_text_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer core testbench
// Feeds source bytes through the valid/stall input channel and checks every
// token on the output channel against a scanner model kept in the bench.
// A directed part covers keywords, byte extremes, comments and end of input.
// Random text of identifiers, numbers, comments and symbols follows under
// three idle patterns. One long receiver hold-off fills the token queue.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_core;

    localparam int NAME_CAP        = sttk_pkg::MAX_IDENT_CHARS_DEF;
    localparam int DIGIT_CAP       = sttk_pkg::MAX_NUMBER_DIGITS_DEF;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;

    // Scanner states of the bench model.
    typedef enum logic [3:0] {
        SCAN_IDLE    = 4'b0001,
        SCAN_IDENT   = 4'b0010,
        SCAN_NUMBER  = 4'b0100,
        SCAN_COMMENT = 4'b1000
    } scan_mode_t;

    // One token as it appears on the output ports.
    typedef struct packed {
        sttk_pkg::kind_t kind;
        logic [7:0]      char_val;
        logic [29:0]     number;
        logic [4:0]      length;
        logic [63:0]     text_low;
        logic [63:0]     text_mid;
        logic [23:0]     text_high;
        logic            last;
    } token_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        src_valid    = 1'b0;
    logic        src_stall;
    logic [7:0]  char_code    = 8'h00;
    logic        end_of_input = 1'b0;
    logic        tok_valid;
    logic        tok_stall    = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  char_value;
    logic [29:0] number_value;
    logic [4:0]  ident_length;
    logic [63:0] ident_text_low;
    logic [63:0] ident_text_mid;
    logic [23:0] ident_text_high;
    logic        last_of_run;

    // Scanner model state.
    scan_mode_t  scan_state    = SCAN_IDLE;
    logic [7:0]  word_chars [NAME_CAP];
    int          word_len      = 0;
    logic [29:0] number_acc    = '0;
    int          number_digits = 0;
    token_t      step_tokens[$];
    token_t      expected_tokens[$];

    // Traffic shaping and bookkeeping.
    int src_idle_pct       = 0;
    int snk_idle_pct       = 0;
    int hold_off_len       = 0;
    int longest_hold_off   = 0;
    int quiet_cycles       = 0;
    int fail_count         = 0;
    int bytes_sent         = 0;
    int comment_body_bytes = 0;
    int tokens_checked     = 0;
    int double_token_steps = 0;
    int kind_seen [8];

    source_text_tokenizer_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .char_code      (char_code),
        .end_of_input   (end_of_input),
        .tok_valid      (tok_valid),
        .tok_stall      (tok_stall),
        .kind           (kind),
        .char_value     (char_value),
        .number_value   (number_value),
        .ident_length   (ident_length),
        .ident_text_low (ident_text_low),
        .ident_text_mid (ident_text_mid),
        .ident_text_high(ident_text_high),
        .last_of_run    (last_of_run)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------

    // Builds a token for the current step; identifiers carry the held text
    // and become keywords on an exact match.
    task automatic queue_token(sttk_pkg::kind_t k, logic [7:0] chv, logic [29:0] num,
                               bit with_text);
        token_t                      t;
        logic [sttk_pkg::TEXT_W-1:0] text;
        int                          i;
        t    = '0;
        text = '0;
        t.kind     = k;
        t.char_val = chv;
        t.number   = num;
        if (with_text) begin
            for (i = 0; i < word_len; i++)
                text[i*8 +: 8] = word_chars[i];
            t.length    = 5'(word_len);
            t.text_low  = text[63:0];
            t.text_mid  = text[127:64];
            t.text_high = text[151:128];
            if (t.length == sttk_pkg::KW_FN_LEN && text[31:0] == sttk_pkg::KW_FN_TEXT)
                t.kind = sttk_pkg::KIND_FN;
            else if (t.length == sttk_pkg::KW_INT_LEN && text[31:0] == sttk_pkg::KW_INT_TEXT)
                t.kind = sttk_pkg::KIND_INT;
            else if (t.length == sttk_pkg::KW_YELL_LEN
                     && text[31:0] == sttk_pkg::KW_YELL_TEXT)
                t.kind = sttk_pkg::KIND_YELL;
        end
        step_tokens.push_back(t);
    endtask

    // Emits the pending identifier or number, if any.
    task automatic flush_pending();
        if (scan_state == SCAN_IDENT)
            queue_token(sttk_pkg::KIND_IDENT, 8'h00, '0, 1'b1);
        else if (scan_state == SCAN_NUMBER)
            queue_token(sttk_pkg::KIND_NUMBER, 8'h00, number_acc, 1'b0);
        scan_state = SCAN_IDLE;
    endtask

    // Scans a byte as the first byte of a new token.
    task automatic begin_token(logic [7:0] c);
        if (is_blank(c)) begin
            scan_state = SCAN_IDLE;
        end else if (is_letter(c)) begin
            word_chars[0] = c;
            word_len      = 1;
            scan_state    = SCAN_IDENT;
        end else if (is_digit(c)) begin
            number_acc    = 30'(c - "0");
            number_digits = 1;
            scan_state    = SCAN_NUMBER;
        end else if (c == sttk_pkg::CHAR_HASH) begin
            scan_state = SCAN_COMMENT;
        end else begin
            queue_token(sttk_pkg::KIND_CHAR, c, '0, 1'b0);
            scan_state = SCAN_IDLE;
        end
    endtask

    // Works out the tokens of one accepted input transfer.
    task automatic predict_tokens(logic [7:0] c, logic eoi);
        token_t t;
        step_tokens.delete();
        if (eoi) begin
            if (scan_state == SCAN_COMMENT)
                scan_state = SCAN_IDLE;
            flush_pending();
            queue_token(sttk_pkg::KIND_END, 8'h00, '0, 1'b0);
        end else begin
            case (scan_state)
                SCAN_IDENT:
                begin
                    if ((is_letter(c) || is_digit(c)) && word_len < NAME_CAP) begin
                        word_chars[word_len] = c;
                        word_len++;
                    end else begin
                        flush_pending();
                        begin_token(c);
                    end
                end
                SCAN_NUMBER:
                begin
                    if (is_digit(c) && number_digits < DIGIT_CAP) begin
                        number_acc = number_acc * 30'd10 + 30'(c - "0");
                        number_digits++;
                    end else begin
                        flush_pending();
                        begin_token(c);
                    end
                end
                SCAN_COMMENT:
                begin
                    if (c == sttk_pkg::CHAR_LF || c == sttk_pkg::CHAR_CR)
                        scan_state = SCAN_IDLE;
                end
                default: begin_token(c);
            endcase
        end
        if (step_tokens.size() > 1)
            double_token_steps++;
        while (step_tokens.size() > 0)
        begin
            t      = step_tokens.pop_front();
            t.last = (step_tokens.size() == 0);
            expected_tokens.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Token checking
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_token();
        token_t want;
        if (expected_tokens.size() == 0) begin
            $error("token with no expectation: kind %0d", kind);
            fail_count++;
        end else begin
            want = expected_tokens.pop_front();
            compare_field("kind", want.kind, kind);
            compare_field("char_value", want.char_val, char_value);
            compare_field("number_value", want.number, number_value);
            compare_field("ident_length", want.length, ident_length);
            compare_field("ident_text_low", want.text_low, ident_text_low);
            compare_field("ident_text_mid", want.text_mid, ident_text_mid);
            compare_field("ident_text_high", want.text_high, ident_text_high);
            compare_field("last_of_run", want.last, last_of_run);
            tokens_checked++;
            kind_seen[want.kind]++;
        end
    endtask

    // Monitor: checks the output transfer first, then predicts from the input
    // transfer of the same edge, and tracks cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (tok_valid && !tok_stall)
                check_token();
            if (src_valid && !src_stall) begin
                predict_tokens(char_code, end_of_input);
                bytes_sent++;
            end
        end
        if (rst_n && ((tok_valid && !tok_stall) || (src_valid && !src_stall)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Watchdog on a stuck handshake.
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_len != 0) begin
                tok_stall <= 1'b1;
                if (hold_off_len > longest_hold_off)
                    longest_hold_off = hold_off_len;
                repeat (hold_off_len) @(negedge clk);
                hold_off_len = 0;
                tok_stall <= 1'b0;
            end else begin
                tok_stall <= ($urandom_range(99) < snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one byte, with a random gap first, and returns at the falling
    // edge after the transfer. Valid stays high when no gap follows.
    task automatic send_byte(logic [7:0] c, logic eoi);
        if ($urandom_range(99) < src_idle_pct) begin
            src_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        src_valid    <= 1'b1;
        char_code    <= c;
        end_of_input <= eoi;
        do @(posedge clk); while (src_stall);
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // Lowers valid and waits until every expected token has arrived.
    task automatic wait_drain();
        src_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? "a" : "A";
        return base + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(3) == 0)
            return "0" + 8'($urandom_range(9));
        return rand_letter();
    endfunction

    // A byte that stands as a character token of its own.
    function automatic logic [7:0] rand_symbol();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (is_letter(c) || is_digit(c) || is_blank(c) || c == sttk_pkg::CHAR_HASH);
        return c;
    endfunction

    function automatic logic [7:0] rand_blank();
        int v;
        v = $urandom_range(5);
        return (v == 5) ? 8'h20 : 8'h09 + 8'(v);
    endfunction

    // Sends one lexical unit of random content, mostly well formed, then an
    // optional blank. Without the blank, units run into each other.
    task automatic send_random_word();
        string      kw;
        int         sel;
        int         len;
        int         i;
        bit         nines;
        logic [7:0] c;
        sel = $urandom_range(99);
        if (sel < 15) begin
            // Keywords and near misses.
            case ($urandom_range(2))
                0:       kw = "fn";
                1:       kw = "int";
                default: kw = "yell";
            endcase
            if ($urandom_range(3) == 0)
                kw = kw.substr(0, kw.len() - 2);
            else if ($urandom_range(3) == 0)
                kw = {kw, "s"};
            if ($urandom_range(5) == 0)
                kw[0] = kw[0] - 8'd32;
            send_text(kw);
        end else if (sel < 40) begin
            // Identifiers, often around the length cap.
            case ($urandom_range(3))
                0:       len = $urandom_range(NAME_CAP - 2, NAME_CAP + 2);
                1:       len = $urandom_range(9, NAME_CAP - 3);
                default: len = $urandom_range(1, 8);
            endcase
            send_byte(rand_letter(), 1'b0);
            repeat (len - 1) send_byte(rand_alnum(), 1'b0);
        end else if (sel < 60) begin
            // Numbers, often around the digit cap.
            if ($urandom_range(2) == 0)
                len = $urandom_range(DIGIT_CAP - 1, DIGIT_CAP + 2);
            else
                len = $urandom_range(1, DIGIT_CAP - 2);
            nines = ($urandom_range(3) == 0);
            for (i = 0; i < len; i++)
                send_byte(nines ? "9" : "0" + 8'($urandom_range(9)), 1'b0);
        end else if (sel < 68) begin
            // Comment with a random body, closed by a line end or end of input.
            send_byte(sttk_pkg::CHAR_HASH, 1'b0);
            len = $urandom_range(0, 6);
            repeat (len)
            begin
                do c = 8'($urandom_range(255));
                while (c == sttk_pkg::CHAR_LF || c == sttk_pkg::CHAR_CR);
                send_byte(c, 1'b0);
            end
            comment_body_bytes += len;
            case ($urandom_range(4))
                0, 1:    send_byte(sttk_pkg::CHAR_LF, 1'b0);
                2, 3:    send_byte(sttk_pkg::CHAR_CR, 1'b0);
                default: send_byte(8'($urandom_range(255)), 1'b1);
            endcase
        end else if (sel < 84) begin
            send_byte(rand_symbol(), 1'b0);
        end else if (sel < 91) begin
            send_byte(8'($urandom_range(255)), 1'b0);
        end else if (sel < 97) begin
            send_byte(rand_blank(), 1'b0);
        end else begin
            send_byte(8'($urandom_range(255)), 1'b1);
        end
        if ($urandom_range(1) == 0)
            send_byte(rand_blank(), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Keywords, byte extremes, comment ends and end of input in each state.
    task automatic test_keywords_and_extremes();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_text("fn int\tyell");
        // Byte zero ends the keyword and is a token itself.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        // A hash ends a number and opens a comment closed by a carriage return.
        send_text("9");
        send_byte(sttk_pkg::CHAR_HASH, 1'b0);
        send_text("z");
        send_byte(sttk_pkg::CHAR_CR, 1'b0);
        // End of input flushes a pending identifier.
        send_text("q");
        send_byte(8'h00, 1'b1);
        // End of input inside a comment gives the end token only.
        send_byte(sttk_pkg::CHAR_HASH, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(sttk_pkg::CHAR_LF, 1'b0);
        send_text("5!");
        send_byte(8'h7F, 1'b0);
        send_text("42");
        send_byte(8'h00, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_text(int src_pct, int snk_pct, int count);
        int start_bytes;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start_bytes  = bytes_sent - comment_body_bytes;
        while (bytes_sent - comment_body_bytes - start_bytes < count)
            send_random_word();
        wait_drain();
    endtask

    // The receiver holds off while the sender keeps offering letter and symbol pairs,
    // each symbol giving two tokens, so the queue fills and the input stalls.
    task automatic test_backpressure_fill();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_off_len = HOLD_OFF_CYCLES;
        repeat (40)
        begin
            send_byte(rand_letter(), 1'b0);
            send_byte(rand_symbol(), 1'b0);
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_keywords_and_extremes();
        test_random_text(16, 59, 430);
        test_backpressure_fill();
        test_random_text(59, 16, 430);
        test_random_text(0, 0, 430);

        $display("Scanned %0d bytes (%0d inside comments) into %0d tokens: %0d keywords,",
                 bytes_sent, comment_body_bytes, tokens_checked,
                 kind_seen[sttk_pkg::KIND_FN] + kind_seen[sttk_pkg::KIND_INT]
                 + kind_seen[sttk_pkg::KIND_YELL]);
        $display("%0d identifiers, %0d numbers, %0d characters, %0d end tokens;",
                 kind_seen[sttk_pkg::KIND_IDENT], kind_seen[sttk_pkg::KIND_NUMBER],
                 kind_seen[sttk_pkg::KIND_CHAR], kind_seen[sttk_pkg::KIND_END]);
        $display("%0d bytes gave two tokens; longest receiver hold-off %0d cycles.",
                 double_token_steps, longest_hold_off);
        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
